// File: hdl/dynamic_exclusion_topn_select_assert.svh
// Assertion macros used by the checker of the top-N precursor selector.
`ifndef DYNAMIC_EXCLUSION_TOPN_SELECT_ASSERT_SVH
`define DYNAMIC_EXCLUSION_TOPN_SELECT_ASSERT_SVH

// same-cycle implication
`define DETS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dets assertion failed");

// next-cycle implication
`define DETS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dets assertion failed");

`endif

// File: hdl/dets_pkg.sv
// Shared types and constants of the top-N precursor selector.
package dets_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int MZ_W              = 32;
    localparam int LIFE_W            = 17;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 32;
    localparam int MAX_W             = 8;
    localparam int EXCL_W            = 16;

    localparam logic [MAX_W-1:0]  MAX_PER_SCAN_RST = 8'd5;
    localparam logic [MZ_W-1:0]   HALF_WINDOW_RST  = 32'd131072;
    localparam logic [EXCL_W-1:0] EXCL_SCANS_RST   = 16'd0;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PER_SCAN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WINDOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXCL_SCANS   = 2'd2;

    localparam logic CMD_SCAN = 1'b0;
    localparam logic CMD_PEAK = 1'b1;

    typedef enum logic [1:0] {
        ST_SCAN_DONE = 2'd0,
        ST_SELECTED  = 2'd1,
        ST_EXCLUDED  = 2'd2,
        ST_QUOTA     = 2'd3
    } t_status;

    typedef struct packed {
        logic load;
        logic sweep;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic quota;
        logic sweep_done;
        logic out_free;
    } t_dp_stat;

endpackage

// File: hdl/dynamic_exclusion_topn_select.sv
// A scan start or a peak under quota sweeps every table entry between load and write-back
// (one read per table entry through the single memory read port); a peak once the scan quota
// is met skips the sweep. One transaction at a time: the next is taken the cycle after
// write-back, while the previous result may still wait.
// Reset (synchronous, active low) empties the table at once and restores config defaults.
module dynamic_exclusion_topn_select import dets_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_cmd,
    input  logic [MZ_W-1:0]       i_peak_mz,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [1:0]            o_status,
    output logic                  o_table_overflow,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd  ctl;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    dets_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_ctl   (ctl)
    );

    dets_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_cmd            (i_cmd),
        .i_peak_mz        (i_peak_mz),
        .i_ready          (i_ready),
        .i_ctl            (ctl),
        .o_stat           (stat),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_table_overflow (o_table_overflow)
    );

endmodule

// File: hdl/dets_ctrl.sv
// Controller state machine: sequences load, table sweep and result write-back.
module dets_ctrl import dets_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_ctl
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SWEEP = 3'b010,
        S_DONE  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        o_ctl.load   = 1'b0;
        o_ctl.sweep  = 1'b0;
        o_ctl.finish = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_SWEEP;
                end
            end
            S_SWEEP: begin
                // quota already met: no need to look at the table
                o_ctl.sweep = !i_stat.quota;
                if (i_stat.quota || i_stat.sweep_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_ctl.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: hdl/dets_dp.sv
// Datapath: config registers, exclusion table memories, sweep and result register.
module dets_dp import dets_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_cmd,
    input  logic [MZ_W-1:0]       i_peak_mz,
    input  logic                  i_ready,
    input  t_dp_cmd               i_ctl,
    output t_dp_stat              o_stat,
    output logic                  o_valid,
    output logic [1:0]            o_status,
    output logic                  o_table_overflow
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(TABLE_ENTRIES);

    // configuration
    logic [MAX_W-1:0]  r_max_per_scan;
    logic [MZ_W-1:0]   r_half_window;
    logic [EXCL_W-1:0] r_excl_scans;

    // current transaction
    logic              r_cmd;
    logic [MZ_W-1:0]   r_mz;
    logic              r_quota;
    logic              r_covered;
    logic              r_free_found;
    logic [IDX_W-1:0]  r_free_idx;

    // sweep pipeline: issue index, then compare in the next cycle
    logic [CNT_W-1:0]  r_iss;
    logic              r_pv;
    logic [IDX_W-1:0]  r_pidx;

    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [MAX_W-1:0]         r_picked;

    logic              r_out_valid;
    t_status           r_status;
    logic              r_ovf;

    logic [MZ_W-1:0]   r_lo_mem   [TABLE_ENTRIES];
    logic [MZ_W-1:0]   r_hi_mem   [TABLE_ENTRIES];
    logic [LIFE_W-1:0] r_life_mem [TABLE_ENTRIES];
    logic [MZ_W-1:0]   r_rd_lo;
    logic [MZ_W-1:0]   r_rd_hi;
    logic [LIFE_W-1:0] r_rd_life;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              proc;
    logic              ent_v;
    logic              hit;
    logic              age_wr;
    logic              age_clr;
    logic              ins_wr;
    logic              life_wr;
    logic [IDX_W-1:0]  life_addr;
    logic [LIFE_W-1:0] life_data;
    logic [MZ_W-1:0]   lo_new;
    logic [MZ_W:0]     hi_sum;
    logic [MZ_W-1:0]   hi_new;
    logic [LIFE_W-1:0] life_new;
    t_status           n_status;
    logic              n_ovf;

    assign rd_en   = i_ctl.sweep && (r_iss != CNT_END);
    assign rd_addr = r_iss[IDX_W-1:0];
    assign proc    = i_ctl.sweep && r_pv;
    assign ent_v   = r_valid[r_pidx];
    assign hit     = ent_v && (r_rd_lo <= r_mz) && (r_mz <= r_rd_hi);

    assign age_wr  = proc && (r_cmd == CMD_SCAN) && ent_v && (r_rd_life > LIFE_W'(1));
    assign age_clr = proc && (r_cmd == CMD_SCAN) && ent_v && (r_rd_life <= LIFE_W'(1));

    // saturating window bounds
    assign lo_new   = (r_mz >= r_half_window) ? (r_mz - r_half_window) : '0;
    assign hi_sum   = {1'b0, r_mz} + {1'b0, r_half_window};
    assign hi_new   = hi_sum[MZ_W] ? '1 : hi_sum[MZ_W-1:0];
    assign life_new = {1'b0, r_excl_scans} + LIFE_W'(1);

    always_comb begin
        n_status = ST_SCAN_DONE;
        n_ovf    = 1'b0;
        ins_wr   = 1'b0;
        if (r_cmd == CMD_SCAN) begin
            n_status = ST_SCAN_DONE;
        end else if (r_quota) begin
            n_status = ST_QUOTA;
        end else if (r_covered) begin
            n_status = ST_EXCLUDED;
        end else begin
            n_status = ST_SELECTED;
            n_ovf    = !r_free_found;
            ins_wr   = i_ctl.finish && r_free_found;
        end
    end

    assign life_wr   = age_wr || ins_wr;
    assign life_addr = ins_wr ? r_free_idx : r_pidx;
    assign life_data = ins_wr ? life_new : (r_rd_life - LIFE_W'(1));

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_lo   <= r_lo_mem[rd_addr];
            r_rd_hi   <= r_hi_mem[rd_addr];
            r_rd_life <= r_life_mem[rd_addr];
        end
        if (ins_wr) begin
            r_lo_mem[r_free_idx] <= lo_new;
            r_hi_mem[r_free_idx] <= hi_new;
        end
        if (life_wr) begin
            r_life_mem[life_addr] <= life_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_per_scan <= MAX_PER_SCAN_RST;
            r_half_window  <= HALF_WINDOW_RST;
            r_excl_scans   <= EXCL_SCANS_RST;
            r_cmd          <= CMD_SCAN;
            r_mz           <= '0;
            r_quota        <= 1'b0;
            r_covered      <= 1'b0;
            r_free_found   <= 1'b0;
            r_free_idx     <= '0;
            r_iss          <= '0;
            r_pv           <= 1'b0;
            r_pidx         <= '0;
            r_valid        <= '0;
            r_picked       <= '0;
            r_out_valid    <= 1'b0;
            r_status       <= ST_SCAN_DONE;
            r_ovf          <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MAX_PER_SCAN: r_max_per_scan <= i_cfg_data[MAX_W-1:0];
                    CFG_HALF_WINDOW:  r_half_window  <= i_cfg_data[MZ_W-1:0];
                    CFG_EXCL_SCANS:   r_excl_scans   <= i_cfg_data[EXCL_W-1:0];
                    default: ;
                endcase
            end

            if (i_ctl.load) begin
                r_cmd        <= i_cmd;
                r_mz         <= i_peak_mz;
                r_quota      <= (i_cmd == CMD_PEAK) && (r_picked >= r_max_per_scan);
                r_covered    <= 1'b0;
                r_free_found <= 1'b0;
                r_iss        <= '0;
                r_pv         <= 1'b0;
            end else if (i_ctl.sweep) begin
                if (rd_en) begin
                    r_iss  <= r_iss + CNT_W'(1);
                    r_pidx <= rd_addr;
                end
                r_pv <= rd_en;
            end

            if (proc && (r_cmd == CMD_PEAK)) begin
                if (hit) begin
                    r_covered <= 1'b1;
                end
                // lowest free slot wins
                if (!ent_v && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_pidx;
                end
            end

            if (age_clr) begin
                r_valid[r_pidx] <= 1'b0;
            end
            if (ins_wr) begin
                r_valid[r_free_idx] <= 1'b1;
            end

            if (i_ctl.finish) begin
                if (r_cmd == CMD_SCAN) begin
                    r_picked <= '0;
                end else if (n_status == ST_SELECTED) begin
                    r_picked <= r_picked + MAX_W'(1);
                end
            end

            if (i_ctl.finish) begin
                r_out_valid <= 1'b1;
                r_status    <= n_status;
                r_ovf       <= n_ovf;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.quota      = r_quota;
    assign o_stat.sweep_done = (r_iss == CNT_END) && !r_pv;
    assign o_stat.out_free   = !r_out_valid || i_ready;

    assign o_valid          = r_out_valid;
    assign o_status         = r_status;
    assign o_table_overflow = r_ovf;

endmodule

// File: hdl/dets_checker.sv
// Port-level checker for the top-N precursor selector, bound to the top level.
`include "dynamic_exclusion_topn_select_assert.svh"

module dets_checker import dets_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [1:0] o_status,
    input logic       o_table_overflow
);

    logic [2:0] res_w;

    assign res_w = {o_status, o_table_overflow};

    // a stalled result holds
    `DETS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(res_w))
    // overflow only accompanies a selection
    `DETS_ASSERT_NOW(a_ovf_sel, i_clk, i_rst_n, o_valid && o_status != ST_SELECTED, !o_table_overflow)
    // one transaction at a time
    `DETS_ASSERT_NEXT(a_busy, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    // no result can appear right after a transaction is taken
    `DETS_ASSERT_NEXT(a_no_early, i_clk, i_rst_n, i_valid && o_ready, !$rose(o_valid))

endmodule

bind dynamic_exclusion_topn_select dets_checker u_dets_checker (.*);
